/* rtl/qes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_pkg
// Shared types, register indexes and helpers for the quadrature encoder
// speed block.
// ----------------------------------------------------------------------------
package qes_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_SPEED_GAIN = 2'd0;
	localparam logic [1:0] REG_ANGLE_GAIN = 2'd1;
	localparam logic [1:0] REG_RATE_GAIN  = 2'd2;

	// Gain reset value: 1.0 in unsigned Q16.16
	localparam logic [31:0] GAIN_RESET = 32'h0001_0000;

	localparam int CountW = 32;
	localparam int PosW   = 30;
	localparam int OutW   = 48;

	// One sample of the encoder pins
	typedef struct packed {
		logic level_a;
		logic level_b;
		logic period_end;
	} sample_t;

	// One result item
	typedef struct packed {
		logic signed [PosW-1:0] position;
		logic signed [OutW-1:0] angle;
		logic signed [OutW-1:0] linear_speed;
		logic signed [OutW-1:0] angular_rate;
		logic                   double_change;
	} result_t;

	// Next decoder state, handed from the decoder to the pipeline
	typedef struct packed {
		logic signed [CountW-1:0] count;
		logic                     double_change;
	} dec_t;

	// Clamp a 64-bit signed product into 48 bits
	function automatic logic signed [OutW-1:0] sat48(input logic signed [63:0] v);
		logic fits;
		fits = (v[63:OutW-1] == {(64-OutW+1){1'b0}}) ||
		       (v[63:OutW-1] == {(64-OutW+1){1'b1}});
		if (fits)
			return v[OutW-1:0];
		else if (v[63])
			return {1'b1, {(OutW-1){1'b0}}};
		else
			return {1'b0, {(OutW-1){1'b1}}};
	endfunction

endpackage

/* rtl/qes_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_decode
// x4 quadrature decoder: holds the last pin levels and the signed edge
// counter, and gives the counter value after the offered sample.
// ----------------------------------------------------------------------------
module qes_decode import qes_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  sample_t sample,
	output dec_t    dec
);

	logic                     last_a_q;
	logic                     last_b_q;
	logic signed [CountW-1:0] count_q;
	logic                     ch_a;
	logic                     ch_b;
	logic                     move;
	logic                     up;

	// Edge detection and direction
	always_comb begin
		ch_a = sample.level_a ^ last_a_q;
		ch_b = sample.level_b ^ last_b_q;
		// exactly one pin changed
		move = ch_a ^ ch_b;
		// A edge: up when A and B differ; B edge: up when they match
		up   = ch_a ? (sample.level_a ^ sample.level_b)
		            : ~(sample.level_a ^ sample.level_b);
		dec.double_change = ch_a & ch_b;
		if (!move)
			dec.count = count_q;
		else if (up)
			dec.count = count_q + 32'sd1;
		else
			dec.count = count_q - 32'sd1;
	end

	// Decoder state, updated once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
			last_b_q <= 1'b0;
			count_q  <= '0;
		end else if (take) begin
			last_a_q <= sample.level_a;
			last_b_q <= sample.level_b;
			count_q  <= dec.count;
		end
	end

endmodule

/* rtl/quadrature_encoder_speed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_speed
// x4 quadrature decoder with position, angle, speed and angular rate.
// ----------------------------------------------------------------------------
// Takes one encoder sample per cycle while sample_ready is high and returns
// one result item per sample, raising result_valid once the item reaches the
// output register. The one-cycle rate is set by the edge counter's update
// loop; the multipliers and saturation behind it are pipelined in five
// stages (count, position, angle product and delta, speed/rate products and
// angle clamp, output register), each with its own valid bit, so bubbles
// close up while the output is stalled. Gains are unsigned Q16.16 and must
// be written through the cfg port only while no item is in flight, which the
// block does not enforce; speed and rate hold their value between period ends.
// ----------------------------------------------------------------------------
module quadrature_encoder_speed import qes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] speed_gain_q;
	logic [31:0] angle_gain_q;
	logic [31:0] rate_gain_q;

	dec_t dec;
	logic take;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [CountW-1:0] count_s1;
	logic                     pend_s1, dbl_s1;

	logic signed [PosW-1:0]   pos_s2;
	logic                     pend_s2, dbl_s2;

	logic signed [PosW-1:0]   pos_s3;
	logic signed [62:0]       angle_prod_s3;
	logic signed [PosW:0]     delta_s3;
	logic                     pend_s3, dbl_s3;

	logic signed [PosW-1:0]   pos_s4;
	logic signed [OutW-1:0]   angle_s4;
	logic signed [63:0]       speed_prod_s4;
	logic signed [63:0]       rate_prod_s4;
	logic                     pend_s4, dbl_s4;

	result_t                  result_s5;

	logic signed [PosW-1:0]   start_pos_q;
	logic signed [OutW-1:0]   held_speed_q;
	logic signed [OutW-1:0]   held_rate_q;

	logic signed [CountW:0]   count_adj;
	logic signed [PosW-1:0]   pos_next;
	logic signed [OutW-1:0]   speed_next;
	logic signed [OutW-1:0]   rate_next;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= GAIN_RESET;
			angle_gain_q <= GAIN_RESET;
			rate_gain_q  <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED_GAIN: speed_gain_q <= cfg_data;
				REG_ANGLE_GAIN: angle_gain_q <= cfg_data;
				REG_RATE_GAIN:  rate_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage readiness: a stage loads when empty or when it drains this cycle
	assign rdy_s5       = !valid_s5 || result_ready;
	assign rdy_s4       = !valid_s4 || rdy_s5;
	assign rdy_s3       = !valid_s3 || rdy_s4;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign sample_ready = !valid_s1 || rdy_s2;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (sample_ready) valid_s1 <= sample_valid;
			if (rdy_s2)       valid_s2 <= valid_s1;
			if (rdy_s3)       valid_s3 <= valid_s2;
			if (rdy_s4)       valid_s4 <= valid_s3;
			if (rdy_s5)       valid_s5 <= valid_s4;
		end
	end

	// Stage 1: edge counter
	qes_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (sample),
		.dec    (dec)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			count_s1 <= dec.count;
			pend_s1  <= sample.period_end;
			dbl_s1   <= dec.double_change;
		end
	end

	// Stage 2: position, count / 4 rounded toward zero
	always_comb begin
		count_adj = {count_s1[CountW-1], count_s1} +
		            (count_s1[CountW-1] ? 33'sd3 : 33'sd0);
		pos_next  = count_adj[PosW+1:2];
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			pos_s2  <= pos_next;
			pend_s2 <= pend_s1;
			dbl_s2  <= dbl_s1;
		end
	end

	// Stage 3: angle product and position change over the period
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			pos_s3        <= pos_s2;
			angle_prod_s3 <= pos_s2 * $signed({1'b0, angle_gain_q});
			delta_s3      <= (PosW+1)'(pos_s2) - (PosW+1)'(start_pos_q);
			pend_s3       <= pend_s2;
			dbl_s3        <= dbl_s2;
		end
	end

	// Period start position moves on when a period-end item leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_pos_q <= '0;
		else if (rdy_s3 && valid_s2 && pend_s2)
			start_pos_q <= pos_s2;
	end

	// Stage 4: speed and rate products, angle clamp
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			pos_s4        <= pos_s3;
			angle_s4      <= sat48(64'(angle_prod_s3));
			speed_prod_s4 <= delta_s3 * $signed({1'b0, speed_gain_q});
			rate_prod_s4  <= delta_s3 * $signed({1'b0, rate_gain_q});
			pend_s4       <= pend_s3;
			dbl_s4        <= dbl_s3;
		end
	end

	// Stage 5: clamp speed and rate, update the held values, output register
	always_comb begin
		speed_next = pend_s4 ? sat48(speed_prod_s4) : held_speed_q;
		rate_next  = pend_s4 ? sat48(rate_prod_s4)  : held_rate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q <= '0;
			held_rate_q  <= '0;
		end else if (rdy_s5 && valid_s4) begin
			held_speed_q <= speed_next;
			held_rate_q  <= rate_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && valid_s4) begin
			result_s5.position      <= pos_s4;
			result_s5.angle         <= angle_s4;
			result_s5.linear_speed  <= speed_next;
			result_s5.angular_rate  <= rate_next;
			result_s5.double_change <= dbl_s4;
		end
	end

	assign result_valid = valid_s5;
	assign result       = result_s5;

endmodule
